/* hw/rtl/wide_char_to_integer_parser_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the wide character to integer parser
// Concurrent checks clocked on the rising edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WIDE_CHAR_TO_INTEGER_PARSER_MACROS_SVH
`define WIDE_CHAR_TO_INTEGER_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every edge outside reset
`define WCIP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle
`define WCIP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle
`define WCIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define WCIP_ASSERT(label, clk, rst, prop, msg)
`define WCIP_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define WCIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* hw/rtl/wcip_pkg.sv */
// ----------------------------------------------------------------------------
// wcip_pkg
// Shared types, codes and the digit decoder of the character parser.
// ----------------------------------------------------------------------------
package wcip_pkg;

  localparam int CHAR_WIDTH      = 16;
  localparam int LIMIT_WIDTH     = 16;
  localparam int CONSUMED_WIDTH  = 17;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_NO_DIGIT = 2'd0,
    STATUS_OK       = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // Parse modes
  localparam logic [1:0] MODE_SIGNED_DEC   = 2'd0;
  localparam logic [1:0] MODE_UNSIGNED_DEC = 2'd1;
  localparam logic [1:0] MODE_HEX          = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PARSE_MODE  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIGIT_LIMIT = 2'd1;

  // Character codes
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 16'h002D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 16'h002B;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 16'h0030;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 16'h0039;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 16'h0061;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 16'h0066;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 16'h0041;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F = 16'h0046;

  // Digit values
  localparam logic [4:0] RADIX_DEC    = 5'd10;
  localparam logic [4:0] RADIX_HEX    = 5'd16;
  localparam logic [4:0] DIGIT_NONE   = 5'd16;
  localparam logic [4:0] LETTER_SHIFT = 5'd9;

  // Configuration register file
  typedef struct packed {
    logic [1:0]             parse_mode;
    logic [LIMIT_WIDTH-1:0] digit_limit;
  } cfg_t;

  // Parse state flags
  typedef struct packed {
    logic parsing;
    logic negative;
    logic sign_seen;
  } flags_t;

  // Result control from the step logic
  typedef struct packed {
    logic    emit;
    status_t status;
  } step_out_t;

  // Digit value 0..15, or DIGIT_NONE when not a digit
  function automatic logic [4:0] decode_digit(input logic [CHAR_WIDTH-1:0] ch,
                                              input logic hex);
    logic [4:0] d;
    d = DIGIT_NONE;
    if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
      d = {1'b0, ch[3:0]};
    end else if (hex && (ch inside {[CHAR_LOWER_A:CHAR_LOWER_F],
                                    [CHAR_UPPER_A:CHAR_UPPER_F]})) begin
      d = {1'b0, ch[3:0]} + LETTER_SHIFT;
    end
    return d;
  endfunction

endpackage

/* hw/rtl/wcip_step.sv */
// ----------------------------------------------------------------------------
// wcip_step
// One character of parse: digit decode, radix multiply, add, bound compare,
// next state and the result it finishes, all in one combinational pass.
// ----------------------------------------------------------------------------
module wcip_step #(
  parameter int VALUE_WIDTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  wcip_pkg::cfg_t                        cfg,
  input  logic [wcip_pkg::CHAR_WIDTH-1:0]       character,
  input  logic                                  string_start,
  input  logic [VALUE_WIDTH-1:0]                acc,
  input  logic [COUNT_WIDTH-1:0]                cnt,
  input  wcip_pkg::flags_t                      flags,
  output logic [VALUE_WIDTH-1:0]                acc_next,
  output logic [COUNT_WIDTH-1:0]                cnt_next,
  output wcip_pkg::flags_t                      flags_next,
  output wcip_pkg::step_out_t                   result,
  output logic [VALUE_WIDTH-1:0]                value,
  output logic [wcip_pkg::CONSUMED_WIDTH-1:0]   consumed
);
  import wcip_pkg::*;

  localparam int BW    = VALUE_WIDTH + 4;
  localparam int CMP_W = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
  localparam int SUM_W = COUNT_WIDTH + 1;
  localparam int EXT_W = (SUM_W > CONSUMED_WIDTH) ? SUM_W : CONSUMED_WIDTH;

  logic                   hex;
  logic                   is_signed;
  logic [VALUE_WIDTH-1:0] acc_cur;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  flags_t                 flags_cur;
  logic                   take_sign;
  logic [4:0]             digit;
  logic                   is_digit;
  logic [BW-1:0]          bound;
  logic [BW-1:0]          product;
  logic [BW-1:0]          grown;
  logic                   over;
  logic                   lim_cur;
  logic                   lim_inc;
  logic [EXT_W-1:0]       count_sum;

  // A string start clears the running parse
  always_comb begin
    hex       = cfg.parse_mode[1];
    is_signed = (cfg.parse_mode == MODE_SIGNED_DEC);
    acc_cur   = string_start ? '0 : acc;
    cnt_cur   = string_start ? '0 : cnt;
    flags_cur = string_start ? '{parsing: 1'b1, negative: 1'b0, sign_seen: 1'b0} : flags;
    cnt_inc   = cnt_cur + COUNT_WIDTH'(1);
    take_sign = string_start && is_signed &&
                ((character == CHAR_MINUS) || (character == CHAR_PLUS));
  end

  // Digit limit or counter saturation, before and after this digit
  assign lim_cur = (CMP_W'(cnt_cur) >= CMP_W'(cfg.digit_limit)) || (&cnt_cur);
  assign lim_inc = (CMP_W'(cnt_inc) >= CMP_W'(cfg.digit_limit)) || (&cnt_inc);

  // Decode and grow: acc*radix + d checked against the bound
  always_comb begin
    digit    = decode_digit(character, hex);
    is_digit = digit < (hex ? RADIX_HEX : RADIX_DEC);
    if (is_signed) begin
      bound = {5'b0, {(VALUE_WIDTH-1){1'b1}}} + BW'(flags_cur.negative);
    end else begin
      bound = {4'b0, {VALUE_WIDTH{1'b1}}};
    end
    if (hex) begin
      product = {acc_cur, 4'b0};
    end else begin
      product = {1'b0, acc_cur, 3'b0} + {3'b0, acc_cur, 1'b0};
    end
    grown = product + BW'(digit);
    over  = grown > bound;
  end

  // Next state and result control
  always_comb begin
    acc_next      = acc_cur;
    cnt_next      = cnt_cur;
    flags_next    = flags_cur;
    result.emit   = 1'b0;
    result.status = STATUS_NO_DIGIT;
    if (take_sign) begin
      flags_next.sign_seen = 1'b1;
      flags_next.negative  = (character == CHAR_MINUS);
      if (lim_cur) begin
        result.emit        = 1'b1;
        flags_next.parsing = 1'b0;
      end
    end else if (!flags_cur.parsing) begin
      // idle character: ignored
    end else if (lim_cur || !is_digit) begin
      result.emit        = 1'b1;
      result.status      = (cnt_cur != '0) ? STATUS_OK : STATUS_NO_DIGIT;
      flags_next.parsing = 1'b0;
    end else if (over) begin
      result.emit        = 1'b1;
      result.status      = STATUS_OVERFLOW;
      flags_next.parsing = 1'b0;
    end else begin
      acc_next = grown[VALUE_WIDTH-1:0];
      cnt_next = cnt_inc;
      if (lim_inc) begin
        result.emit        = 1'b1;
        result.status      = STATUS_OK;
        flags_next.parsing = 1'b0;
      end
    end
  end

  // Result payload from the state as it stands after this character
  always_comb begin
    value     = flags_next.negative ? (VALUE_WIDTH'(0) - acc_next) : acc_next;
    count_sum = EXT_W'(cnt_next) + EXT_W'(flags_next.sign_seen);
    if (count_sum > EXT_W'({CONSUMED_WIDTH{1'b1}})) begin
      consumed = '1;
    end else begin
      consumed = count_sum[CONSUMED_WIDTH-1:0];
    end
  end

endmodule

/* hw/rtl/wide_char_to_integer_parser.sv */
// ----------------------------------------------------------------------------
// wide_char_to_integer_parser: streaming strtol-style wide character parser
// Input register, one decode/multiply/add/compare stage, result register.
// Throughput: one character per cycle unless the result channel stalls.
// Reset: synchronous; idle, parse_mode signed decimal, digit_limit 65535.
// ----------------------------------------------------------------------------
`include "wide_char_to_integer_parser_macros.svh"

module wide_char_to_integer_parser #(
  parameter int VALUE_WIDTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // character channel
  input  logic                                  char_valid,
  output logic                                  char_stall,
  input  logic [wcip_pkg::CHAR_WIDTH-1:0]       character,
  input  logic                                  string_start,
  // result channel
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output wcip_pkg::status_t                     status,
  output logic [VALUE_WIDTH-1:0]                value,
  output logic [wcip_pkg::CONSUMED_WIDTH-1:0]   consumed,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wcip_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [wcip_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import wcip_pkg::*;

  cfg_t                          cfg;
  logic                          char_held;
  logic [CHAR_WIDTH-1:0]         char_reg;
  logic                          start_reg;
  logic [VALUE_WIDTH-1:0]        acc;
  logic [COUNT_WIDTH-1:0]        cnt;
  flags_t                        flags;
  logic [VALUE_WIDTH-1:0]        acc_next;
  logic [COUNT_WIDTH-1:0]        cnt_next;
  flags_t                        flags_next;
  step_out_t                     step;
  logic [VALUE_WIDTH-1:0]        step_value;
  logic [CONSUMED_WIDTH-1:0]     step_consumed;
  logic                          advance;
  logic                          char_accept;

  // Handshake: the held character moves on when the result slot is free
  assign cfg_ready   = 1'b1;
  assign advance     = char_held && (!result_valid || !result_stall);
  assign char_stall  = char_held && !advance;
  assign char_accept = char_valid && !char_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.parse_mode  <= MODE_SIGNED_DEC;
      cfg.digit_limit <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PARSE_MODE:  cfg.parse_mode  <= cfg_data[1:0];
        CFG_DIGIT_LIMIT: cfg.digit_limit <= cfg_data[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_held <= 1'b0;
    end else if (char_accept) begin
      char_held <= 1'b1;
    end else if (advance) begin
      char_held <= 1'b0;
    end
    if (char_accept) begin
      char_reg  <= character;
      start_reg <= string_start;
    end
  end

  wcip_step #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg          (cfg),
    .character    (char_reg),
    .string_start (start_reg),
    .acc          (acc),
    .cnt          (cnt),
    .flags        (flags),
    .acc_next     (acc_next),
    .cnt_next     (cnt_next),
    .flags_next   (flags_next),
    .result       (step),
    .value        (step_value),
    .consumed     (step_consumed)
  );

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      cnt   <= '0;
      flags <= '0;
    end else if (advance) begin
      acc   <= acc_next;
      cnt   <= cnt_next;
      flags <= flags_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && step.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance && step.emit) begin
      status   <= step.status;
      value    <= step_value;
      consumed <= step_consumed;
    end
  end

  // Checks
  `WCIP_ASSERT_NEXT(a_emit_shows, clk, rst, advance && step.emit, result_valid, "result lost")
  `WCIP_ASSERT_NEXT(a_emit_idles, clk, rst, advance && step.emit, !flags.parsing, "parse still open after result")
  `WCIP_ASSERT_SAME(a_no_digit_zero, clk, rst, result_valid && (status == STATUS_NO_DIGIT), value == '0, "no-digit result has nonzero value")
  `WCIP_ASSERT_SAME(a_ok_consumed, clk, rst, result_valid && (status == STATUS_OK), consumed != '0, "success with nothing consumed")
  `WCIP_ASSERT_SAME(a_stall_cause, clk, rst, char_stall, char_held && result_valid && result_stall, "character stalled without cause")

endmodule
